// File: design/gtaf_pkg.sv
// shared types and constants of the greedy tour arc filter
`timescale 1ns / 1ps

package gtaf_pkg;

  localparam int NODE_W   = 6;
  localparam int WEIGHT_W = 32;
  localparam int COUNT_W  = 7;
  localparam int LEN_W    = 48;
  localparam int REG_IDX_W = 1;

  localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 7'd64;
  localparam logic [LEN_W-1:0]   LEN_MAX          = {LEN_W{1'b1}};

  localparam logic CMD_CLEAR = 1'b0;
  localparam logic CMD_OFFER = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_NODE_COUNT = 1'b0;

  typedef struct packed {
    logic                command;
    logic [NODE_W-1:0]   arc_source;
    logic [NODE_W-1:0]   arc_target;
    logic [WEIGHT_W-1:0] arc_weight;
  } gtaf_in_t;

  typedef struct packed {
    logic               accepted;
    logic [COUNT_W-1:0] chosen_count;
    logic [LEN_W-1:0]   tour_length;
    logic [NODE_W-1:0]  tour_start;
  } gtaf_out_t;

  typedef struct packed {
    logic              wr_en;
    logic [NODE_W-1:0] wr_addr;
    logic [NODE_W-1:0] wr_data;
    logic              rd_en;
    logic [NODE_W-1:0] rd_addr;
  } gtaf_mem_req_t;

endpackage

// File: design/gtaf_succ_mem.sv
// successor pointer memory, one write and one registered read port
`timescale 1ns / 1ps

module gtaf_succ_mem #(
  parameter int DEPTH = 64
) (
  input  logic                          clk,
  input  gtaf_pkg::gtaf_mem_req_t       req,
  output logic [gtaf_pkg::NODE_W-1:0]   rd_data
);

  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [gtaf_pkg::NODE_W-1:0] mem [DEPTH];
  logic [gtaf_pkg::NODE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[SLOT_W-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr[SLOT_W-1:0]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/gtaf_regs.sv
// configuration register block with node count
`timescale 1ns / 1ps

module gtaf_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output logic [gtaf_pkg::COUNT_W-1:0] node_count
);

  logic [gtaf_pkg::COUNT_W-1:0] node_count_r;
  logic [gtaf_pkg::COUNT_W-1:0] node_count_nxt;
  logic                         hit_node_count;

  assign hit_node_count = (paddr[2] == gtaf_pkg::REG_NODE_COUNT);

  always_comb begin
    node_count_nxt = node_count_r;
    if (psel && penable && pwrite && pready && hit_node_count) begin
      node_count_nxt = pwdata[gtaf_pkg::COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= gtaf_pkg::NODE_COUNT_RESET;
    end else begin
      node_count_r <= node_count_nxt;
    end
  end

  assign pready     = 1'b1;
  assign prdata     = hit_node_count ? {{(32 - gtaf_pkg::COUNT_W){1'b0}}, node_count_r} : 32'd0;
  assign node_count = node_count_r;

endmodule

// File: design/gtaf_tour_fsm.sv
// arc check sequencer: marks, subtour walk over successor memory, tour totals
`timescale 1ns / 1ps

module gtaf_tour_fsm #(
  parameter int MAX_NODES  = 64,
  parameter int NODE_SLOTS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [gtaf_pkg::COUNT_W-1:0]  node_count,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  gtaf_pkg::gtaf_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output gtaf_pkg::gtaf_out_t           out_data,
  output gtaf_pkg::gtaf_mem_req_t       mem_req,
  input  logic [gtaf_pkg::NODE_W-1:0]   mem_rd_data
);

  localparam int SLOT_W = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
  localparam int STEP_W = $clog2(MAX_NODES + 1);
  localparam int CNT_W  = (STEP_W > gtaf_pkg::COUNT_W) ? STEP_W : gtaf_pkg::COUNT_W;
  localparam int NW     = gtaf_pkg::NODE_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_DONE
  } state_t;

  state_t                       state_r, state_nxt;
  logic                         cmd_r, cmd_nxt;
  logic [NW-1:0]                src_r, src_nxt;
  logic [NW-1:0]                tgt_r, tgt_nxt;
  logic [gtaf_pkg::WEIGHT_W-1:0] w_r, w_nxt;
  logic [STEP_W-1:0]            steps_r, steps_nxt;
  logic [NODE_SLOTS-1:0]        has_succ_r, has_succ_nxt;
  logic [NODE_SLOTS-1:0]        has_pred_r, has_pred_nxt;
  logic [gtaf_pkg::COUNT_W-1:0] chosen_r, chosen_nxt;
  logic [gtaf_pkg::LEN_W-1:0]   len_r, len_nxt;
  logic                         start_valid_r, start_valid_nxt;
  logic [NW-1:0]                start_r, start_nxt;
  logic                         res_acc_r, res_acc_nxt;
  logic                         out_valid_r, out_valid_nxt;
  gtaf_pkg::gtaf_out_t          out_data_r, out_data_nxt;

  logic [CNT_W-1:0]             nc_ext;
  logic [CNT_W-1:0]             eff_n;
  logic                         range_ok;
  logic                         marks_ok;
  logic                         need_walk;
  logic                         do_commit;
  logic                         do_clear;
  logic                         out_free;
  logic [STEP_W-1:0]            step_inc;
  logic [gtaf_pkg::LEN_W:0]     len_sum;

  assign in_ready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ready;

  assign nc_ext = CNT_W'(node_count);
  always_comb begin
    if (nc_ext < CNT_W'(2)) begin
      eff_n = CNT_W'(2);
    end else if (nc_ext > CNT_W'(MAX_NODES)) begin
      eff_n = CNT_W'(MAX_NODES);
    end else begin
      eff_n = nc_ext;
    end
  end

  assign range_ok  = (CNT_W'(src_r) < eff_n) && (CNT_W'(tgt_r) < eff_n) && (src_r != tgt_r);
  assign marks_ok  = range_ok && !has_succ_r[src_r[SLOT_W-1:0]]
                     && !has_pred_r[tgt_r[SLOT_W-1:0]];
  assign need_walk = (CNT_W'(chosen_r) < (eff_n - CNT_W'(1)));
  assign step_inc  = steps_r + STEP_W'(1);
  assign len_sum   = {1'b0, len_r} + (gtaf_pkg::LEN_W + 1)'(w_r);

  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    src_nxt         = src_r;
    tgt_nxt         = tgt_r;
    w_nxt           = w_r;
    steps_nxt       = steps_r;
    has_succ_nxt    = has_succ_r;
    has_pred_nxt    = has_pred_r;
    chosen_nxt      = chosen_r;
    len_nxt         = len_r;
    start_valid_nxt = start_valid_r;
    start_nxt       = start_r;
    res_acc_nxt     = res_acc_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_data_nxt    = out_data_r;
    mem_req         = '0;
    do_commit       = 1'b0;
    do_clear        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_data.command;
          src_nxt   = in_data.arc_source;
          tgt_nxt   = in_data.arc_target;
          w_nxt     = in_data.arc_weight;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (cmd_r == gtaf_pkg::CMD_CLEAR) begin
          do_clear    = 1'b1;
          res_acc_nxt = 1'b0;
          state_nxt   = ST_DONE;
        end else if (!marks_ok) begin
          res_acc_nxt = 1'b0;
          state_nxt   = ST_DONE;
        end else if (!need_walk || !has_succ_r[tgt_r[SLOT_W-1:0]]) begin
          do_commit   = 1'b1;
          res_acc_nxt = 1'b1;
          state_nxt   = ST_DONE;
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = tgt_r;
          steps_nxt       = '0;
          state_nxt       = ST_WALK;
        end
      end
      ST_WALK: begin
        if (mem_rd_data == src_r) begin
          res_acc_nxt = 1'b0;
          state_nxt   = ST_DONE;
        end else if (step_inc == STEP_W'(MAX_NODES)
                     || !has_succ_r[mem_rd_data[SLOT_W-1:0]]) begin
          do_commit   = 1'b1;
          res_acc_nxt = 1'b1;
          state_nxt   = ST_DONE;
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = mem_rd_data;
          steps_nxt       = step_inc;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.accepted     = res_acc_r;
          out_data_nxt.chosen_count = chosen_r;
          out_data_nxt.tour_length  = len_r;
          out_data_nxt.tour_start   = start_valid_r ? start_r : '0;
          state_nxt                 = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (do_clear) begin
      has_succ_nxt    = '0;
      has_pred_nxt    = '0;
      chosen_nxt      = '0;
      len_nxt         = '0;
      start_valid_nxt = 1'b0;
    end

    if (do_commit) begin
      has_succ_nxt[src_r[SLOT_W-1:0]] = 1'b1;
      has_pred_nxt[tgt_r[SLOT_W-1:0]] = 1'b1;
      chosen_nxt      = chosen_r + gtaf_pkg::COUNT_W'(1);
      len_nxt         = len_sum[gtaf_pkg::LEN_W] ? gtaf_pkg::LEN_MAX
                                                 : len_sum[gtaf_pkg::LEN_W-1:0];
      mem_req.wr_en   = 1'b1;
      mem_req.wr_addr = src_r;
      mem_req.wr_data = tgt_r;
      if (!start_valid_r) begin
        start_valid_nxt = 1'b1;
        start_nxt       = src_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      has_succ_r    <= '0;
      has_pred_r    <= '0;
      chosen_r      <= '0;
      len_r         <= '0;
      start_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      has_succ_r    <= has_succ_nxt;
      has_pred_r    <= has_pred_nxt;
      chosen_r      <= chosen_nxt;
      len_r         <= len_nxt;
      start_valid_r <= start_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    src_r      <= src_nxt;
    tgt_r      <= tgt_nxt;
    w_r        <= w_nxt;
    steps_r    <= steps_nxt;
    start_r    <= start_nxt;
    res_acc_r  <= res_acc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: design/greedy_tour_arc_filter_core.sv
// top level of the greedy tour arc filter
//
//   channel  direction  handshake                    word
//   in       input      in_valid / in_ready          gtaf_in_t
//   out      output     out_valid / out_ready        gtaf_out_t
//   cfg      input      psel penable pwrite pready   pwdata / prdata
//
// a word passes ST_IDLE, ST_CHECK and ST_DONE, with ST_WALK in between for the subtour walk,
// at most MAX_NODES successor reads, made one at a time through the single read port of the successor memory
// reset clears marks, count, length and start at once; node_count resets to 64
// a finished word waits in the output register while out_ready is low;
// a new input word is taken once the previous one has reached that register
`timescale 1ns / 1ps

module greedy_tour_arc_filter_core #(
  parameter int MAX_NODES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gtaf_pkg::gtaf_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output gtaf_pkg::gtaf_out_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int NODE_SLOTS = (MAX_NODES < (1 << gtaf_pkg::NODE_W)) ? MAX_NODES
                                                                    : (1 << gtaf_pkg::NODE_W);

  logic [gtaf_pkg::COUNT_W-1:0] node_count;
  gtaf_pkg::gtaf_mem_req_t      mem_req;
  logic [gtaf_pkg::NODE_W-1:0]  mem_rd_data;

  gtaf_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .node_count (node_count)
  );

  gtaf_succ_mem #(
    .DEPTH (NODE_SLOTS)
  ) u_succ_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

  gtaf_tour_fsm #(
    .MAX_NODES  (MAX_NODES),
    .NODE_SLOTS (NODE_SLOTS)
  ) u_tour_fsm (
    .clk         (clk),
    .rst_n       (rst_n),
    .node_count  (node_count),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .mem_req     (mem_req),
    .mem_rd_data (mem_rd_data)
  );

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a word is in flight");

  a_accept_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.accepted |-> out_data.chosen_count != '0)
    else $error("accepted arc with zero chosen count");

  a_empty_tour: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.chosen_count == '0
      |-> out_data.tour_length == '0 && out_data.tour_start == '0)
    else $error("empty tour with nonzero length or start");
`endif

endmodule
